// ===== rtl/aeba_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the aligned extent block allocator.
package aeba_pkg;

	localparam int BLOCK_BITS = 32;
	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;
	localparam int CLASS_W  = 2;
	localparam int RUN_W    = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOSPACE  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

	localparam logic [CLASS_W-1:0] CLASS_ONE   = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_SMALL = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_BIG   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_FREE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USED_BYTES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT  = 3'd4;

	// cell operations, applied relative to the cell holding the token (i)
	localparam logic [3:0] OP_NOP         = 4'd0;
	localparam logic [3:0] OP_WRITE       = 4'd1; // entry i = (a, b)
	localparam logic [3:0] OP_SET_HI      = 4'd2; // hi[i] = a
	localparam logic [3:0] OP_SET_LO      = 4'd3; // lo[i] = a
	localparam logic [3:0] OP_SET_LO_NEXT = 4'd4; // lo[i+1] = a
	localparam logic [3:0] OP_MERGE       = 4'd5; // hi[i] = hi[i+1], drop i+1
	localparam logic [3:0] OP_DEL         = 4'd6; // drop i
	localparam logic [3:0] OP_INS         = 4'd7; // insert (a, b) at i+1
	localparam logic [3:0] OP_SPLIT       = 4'd8; // hi[i] = a, insert (b, old hi[i])

	typedef struct packed {
		logic       start;
		logic       adv;
		logic       apply;
		logic [3:0] op;
	} cell_ctl_t;

	function automatic logic [RUN_W-1:0] run_size(input logic [CLASS_W-1:0] cls);
		logic [RUN_W-1:0] n;
		unique case (cls)
			CLASS_ONE:   n = 19'd1;
			CLASS_SMALL: n = 19'd512;
			CLASS_BIG:   n = 19'd262144;
			default:     n = '0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/aeba_cell.sv =====
`timescale 1ns / 1ps
// One table entry of the range chain: holds a range, passes the scan token on.
module aeba_cell #(
	parameter int  BLOCK_BITS = 32,
	parameter bit  FIRST      = 1'b0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  aeba_pkg::cell_ctl_t      ctl,
	input  logic [BLOCK_BITS-1:0]    a,
	input  logic [BLOCK_BITS-1:0]    b,
	input  logic                     l_tok,
	input  logic [BLOCK_BITS-1:0]    l_lo,
	input  logic [BLOCK_BITS-1:0]    l_hi,
	input  logic [BLOCK_BITS-1:0]    r_lo,
	input  logic [BLOCK_BITS-1:0]    r_hi,
	output logic                     tok,
	output logic [BLOCK_BITS-1:0]    lo,
	output logic [BLOCK_BITS-1:0]    hi,
	output logic [BLOCK_BITS-1:0]    v_lo,
	output logic [BLOCK_BITS-1:0]    v_hi,
	output logic [BLOCK_BITS-1:0]    v_nlo
);

	logic                  tok_q;
	logic                  seen_q;
	logic [BLOCK_BITS-1:0] lo_q;
	logic [BLOCK_BITS-1:0] hi_q;
	logic                  ahead;
	logic                  is_next;

	assign ahead   = !seen_q && !tok_q;
	assign is_next = ahead && l_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			seen_q <= 1'b0;
		end else if (ctl.start) begin
			tok_q  <= FIRST;
			seen_q <= 1'b0;
		end else if (ctl.adv) begin
			seen_q <= seen_q | tok_q;
			tok_q  <= l_tok;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			unique case (ctl.op)
				aeba_pkg::OP_WRITE: begin
					if (tok_q) begin
						lo_q <= a;
						hi_q <= b;
					end
				end
				aeba_pkg::OP_SET_HI: begin
					if (tok_q) hi_q <= a;
				end
				aeba_pkg::OP_SET_LO: begin
					if (tok_q) lo_q <= a;
				end
				aeba_pkg::OP_SET_LO_NEXT: begin
					if (is_next) lo_q <= a;
				end
				aeba_pkg::OP_MERGE: begin
					if (tok_q) hi_q <= r_hi;
					if (ahead) begin
						lo_q <= r_lo;
						hi_q <= r_hi;
					end
				end
				aeba_pkg::OP_DEL: begin
					if (tok_q || ahead) begin
						lo_q <= r_lo;
						hi_q <= r_hi;
					end
				end
				aeba_pkg::OP_INS: begin
					if (is_next) begin
						lo_q <= a;
						hi_q <= b;
					end else if (ahead) begin
						lo_q <= l_lo;
						hi_q <= l_hi;
					end
				end
				aeba_pkg::OP_SPLIT: begin
					if (tok_q) hi_q <= a;
					if (is_next) begin
						lo_q <= b;
						hi_q <= l_hi;
					end else if (ahead) begin
						lo_q <= l_lo;
						hi_q <= l_hi;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign tok   = tok_q;
	assign lo    = lo_q;
	assign hi    = hi_q;
	assign v_lo  = tok_q ? lo_q : '0;
	assign v_hi  = tok_q ? hi_q : '0;
	assign v_nlo = tok_q ? r_lo : '0;

endmodule

// ===== rtl/aligned_extent_block_allocator.sv =====
`timescale 1ns / 1ps
// Top level: request control, config registers and the chain of range cells.
//
// Requests enter on the s_t* channel (alloc, free or init); each yields one
// response on the m_t* channel with status, allocated block and free count.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, since the block itself does not enforce this.
// The table lives in a chain of MAX_RANGES cells. A scan token starts at
// cell 0 and moves one cell per cycle; the cell holding it is checked, and
// on a match all cells update together, shifting or rewriting entries.
// A rejected run or an unused request type goes straight to the response;
// init first writes the initial range, and alloc and free first walk
// the entries (up to the range count) until one matches. One request is
// worked at a time; the scan token stepping through the cells sets the rate.
// Reset clears the range count, free count and config registers (block
// shift to 12); the table contents are undefined until init.
// A stalled response is held in the output register; the next request is
// taken once the block is idle, and its response waits for that register.
module aligned_extent_block_allocator #(
	parameter int MAX_RANGES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [39:0]                          s_tdata,  // req_type, block_number, size_class
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [71:0]                          m_tdata,  // status, alloc_block, free_count
	input  logic                                 cfg_we,
	input  logic [aeba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [aeba_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int B  = aeba_pkg::BLOCK_BITS;
	localparam int CW = $clog2(MAX_RANGES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INIT = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	// config
	logic [31:0] rstart_q, rend_q, ifree_q;
	logic [39:0] ubytes_q;
	logic [4:0]  bshift_q;

	logic [1:0]  state_q;
	logic [CW-1:0] count_q, idx_q;
	logic [31:0] free_q;

	logic [aeba_pkg::REQ_W-1:0] req_q;
	logic [B:0]   n_q;
	logic [B-1:0] nm1_q, flo_q, fhi_q, fhip1_q, flom1_q;
	logic [31:0]  n32_q;

	logic [aeba_pkg::STATUS_W-1:0] res_status_q;
	logic [31:0] res_where_q;

	logic                              out_valid_q;
	logic [aeba_pkg::STATUS_W-1:0]     out_status_q;
	logic [31:0]                       out_where_q, out_free_q;

	// request decode at accept
	logic accept;
	logic [aeba_pkg::REQ_W-1:0]   in_req;
	logic [63:0]  in_blk64, n64, nm1_64;
	logic [64:0]  fsum, fend;
	logic [aeba_pkg::RUN_W-1:0] in_n;
	logic bad_run, bad_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign in_req   = s_tdata[1:0];
	assign in_blk64 = {32'd0, s_tdata[33:2]};
	assign in_n     = aeba_pkg::run_size(s_tdata[35:34]);
	assign n64      = {45'd0, in_n};
	assign nm1_64   = n64 - 64'd1;
	assign fsum     = {1'b0, 64'(in_blk64[B-1:0])} + {1'b0, nm1_64};
	assign fend     = {1'b0, 64'(in_blk64[B-1:0])} + {1'b0, n64};
	assign bad_run  = (in_n == '0) || ((nm1_64 >> B) != 64'd0);
	assign bad_free = bad_run || ((fsum >> B) != 65'd0);

	// cell chain
	logic [MAX_RANGES-1:0] tok_w;
	logic [B-1:0] lo_w [MAX_RANGES];
	logic [B-1:0] hi_w [MAX_RANGES];
	logic [B-1:0] vlo_w [MAX_RANGES];
	logic [B-1:0] vhi_w [MAX_RANGES];
	logic [B-1:0] vnlo_w [MAX_RANGES];
	aeba_pkg::cell_ctl_t ctl;
	logic [B-1:0] cmd_a, cmd_b;

	for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
		logic         l_tok;
		logic [B-1:0] l_lo, l_hi, r_lo, r_hi;
		if (k == 0) begin : g_left_edge
			assign l_tok = 1'b0;
			assign l_lo  = '0;
			assign l_hi  = '0;
		end else begin : g_left
			assign l_tok = tok_w[k-1];
			assign l_lo  = lo_w[k-1];
			assign l_hi  = hi_w[k-1];
		end
		if (k == MAX_RANGES - 1) begin : g_right_edge
			assign r_lo = '0;
			assign r_hi = '0;
		end else begin : g_right
			assign r_lo = lo_w[k+1];
			assign r_hi = hi_w[k+1];
		end
		aeba_cell #(
			.BLOCK_BITS (B),
			.FIRST      (k == 0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.a      (cmd_a),
			.b      (cmd_b),
			.l_tok  (l_tok),
			.l_lo   (l_lo),
			.l_hi   (l_hi),
			.r_lo   (r_lo),
			.r_hi   (r_hi),
			.tok    (tok_w[k]),
			.lo     (lo_w[k]),
			.hi     (hi_w[k]),
			.v_lo   (vlo_w[k]),
			.v_hi   (vhi_w[k]),
			.v_nlo  (vnlo_w[k])
		);
	end

	// view of the cell holding the token
	logic [B-1:0] c_lo, c_hi, c_nlo;
	always_comb begin
		c_lo  = '0;
		c_hi  = '0;
		c_nlo = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			c_lo  = c_lo | vlo_w[k];
			c_hi  = c_hi | vhi_w[k];
			c_nlo = c_nlo | vnlo_w[k];
		end
	end

	// step evaluation
	logic         e_valid, has_next;
	logic [B-1:0] rend_b, next_low, nlo_m1, a_hi_new;
	logic [B:0]   a_sum, a_lo_new, hi_p1;
	logic         a_fit, a_grow, a_join;
	logic         hit, needs_ins;
	logic [3:0]   hit_op;
	logic [B-1:0] hit_a, hit_b;
	logic [CW-1:0] idx_p1;

	assign rend_b   = rend_q;
	assign e_valid  = idx_q < count_q;
	assign idx_p1   = idx_q + CW'(1);
	assign has_next = idx_p1 < count_q;
	assign next_low = has_next ? c_nlo : rend_b;
	assign nlo_m1   = next_low - B'(1);
	assign a_sum    = {1'b0, c_hi} + n_q;
	assign a_lo_new = a_sum & ~{1'b0, nm1_q};
	assign a_hi_new = a_lo_new[B-1:0] | nm1_q;
	assign hi_p1    = {1'b0, c_hi} + (B+1)'(1);
	assign a_fit    = !a_sum[B] && (a_hi_new < next_low);
	assign a_grow   = (a_lo_new == hi_p1);
	assign a_join   = has_next && (a_hi_new == nlo_m1);

	always_comb begin
		hit    = 1'b0;
		hit_op = aeba_pkg::OP_NOP;
		hit_a  = '0;
		hit_b  = '0;
		if (req_q == aeba_pkg::REQ_ALLOC) begin
			if (a_fit) begin
				hit = 1'b1;
				priority if (a_grow && a_join) begin
					hit_op = aeba_pkg::OP_MERGE;
				end else if (a_grow) begin
					hit_op = aeba_pkg::OP_SET_HI;
					hit_a  = a_hi_new;
				end else if (a_join) begin
					hit_op = aeba_pkg::OP_SET_LO_NEXT;
					hit_a  = a_lo_new[B-1:0];
				end else begin
					hit_op = aeba_pkg::OP_INS;
					hit_a  = a_lo_new[B-1:0];
					hit_b  = a_hi_new;
				end
			end
		end else if (flo_q <= c_hi) begin
			hit = 1'b1;
			priority if (flo_q == c_lo && fhi_q == c_hi) begin
				hit_op = aeba_pkg::OP_DEL;
			end else if (flo_q == c_lo && fhi_q < c_hi) begin
				hit_op = aeba_pkg::OP_SET_LO;
				hit_a  = fhip1_q;
			end else if (flo_q > c_lo && fhi_q == c_hi) begin
				hit_op = aeba_pkg::OP_SET_HI;
				hit_a  = flom1_q;
			end else if (flo_q > c_lo && fhi_q < c_hi) begin
				hit_op = aeba_pkg::OP_SPLIT;
				hit_a  = flom1_q;
				hit_b  = fhip1_q;
			end else begin
				hit = 1'b0;
			end
		end
	end

	assign needs_ins = (hit_op == aeba_pkg::OP_INS) || (hit_op == aeba_pkg::OP_SPLIT);

	// init range
	logic [63:0] bsize, used, init_hi;
	assign bsize   = 64'd1 << bshift_q;
	assign used    = ({24'd0, ubytes_q} + bsize - 64'd1) >> bshift_q;
	assign init_hi = {32'd0, rstart_q} + used - 64'd1;

	logic scan_hit, table_full;
	assign scan_hit   = (state_q == S_SCAN) && e_valid && hit;
	assign table_full = needs_ins && (count_q == CW'(MAX_RANGES));

	always_comb begin
		ctl.start = accept;
		ctl.adv   = (state_q == S_SCAN) && e_valid && !hit;
		ctl.apply = 1'b0;
		ctl.op    = aeba_pkg::OP_NOP;
		cmd_a     = hit_a;
		cmd_b     = hit_b;
		if (state_q == S_INIT) begin
			ctl.apply = 1'b1;
			ctl.op    = aeba_pkg::OP_WRITE;
			cmd_a     = rstart_q;
			cmd_b     = init_hi[B-1:0];
		end else if (scan_hit && !table_full) begin
			ctl.apply = 1'b1;
			ctl.op    = hit_op;
		end
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rstart_q <= '0;
			rend_q   <= '0;
			ifree_q  <= '0;
			ubytes_q <= '0;
			bshift_q <= 5'd12;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aeba_pkg::CFG_REGION_START: rstart_q <= cfg_wdata[31:0];
				aeba_pkg::CFG_REGION_END:   rend_q   <= cfg_wdata[31:0];
				aeba_pkg::CFG_INIT_FREE:    ifree_q  <= cfg_wdata[31:0];
				aeba_pkg::CFG_USED_BYTES:   ubytes_q <= cfg_wdata;
				aeba_pkg::CFG_BLOCK_SHIFT:  bshift_q <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= in_req;
			n_q     <= n64[B:0];
			nm1_q   <= nm1_64[B-1:0];
			n32_q   <= {13'd0, in_n};
			flo_q   <= in_blk64[B-1:0];
			fhi_q   <= fsum[B-1:0];
			fhip1_q <= fend[B-1:0];
			flom1_q <= in_blk64[B-1:0] - B'(1);
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_where_q  <= res_where_q;
			out_free_q   <= free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			free_q       <= '0;
			res_status_q <= aeba_pkg::STAT_OK;
			res_where_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q        <= '0;
						res_status_q <= aeba_pkg::STAT_OK;
						res_where_q  <= '0;
						priority if (in_req == aeba_pkg::REQ_INIT) begin
							state_q <= S_INIT;
						end else if (in_req == aeba_pkg::REQ_ALLOC && bad_run) begin
							res_status_q <= aeba_pkg::STAT_NOSPACE;
							state_q      <= S_DONE;
						end else if (in_req == aeba_pkg::REQ_FREE && bad_free) begin
							res_status_q <= aeba_pkg::STAT_NOTFOUND;
							state_q      <= S_DONE;
						end else if (in_req == aeba_pkg::REQ_ALLOC ||
						             in_req == aeba_pkg::REQ_FREE) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_INIT: begin
					count_q <= CW'(1);
					free_q  <= ifree_q - used[31:0];
					state_q <= S_DONE;
				end
				S_SCAN: begin
					priority if (!e_valid) begin
						res_status_q <= (req_q == aeba_pkg::REQ_ALLOC) ?
							aeba_pkg::STAT_NOSPACE : aeba_pkg::STAT_NOTFOUND;
						state_q <= S_DONE;
					end else if (hit && table_full) begin
						res_status_q <= aeba_pkg::STAT_FULL;
						state_q      <= S_DONE;
					end else if (hit) begin
						if (hit_op == aeba_pkg::OP_MERGE || hit_op == aeba_pkg::OP_DEL) begin
							count_q <= count_q - CW'(1);
						end else if (needs_ins) begin
							count_q <= count_q + CW'(1);
						end
						if (req_q == aeba_pkg::REQ_ALLOC) begin
							free_q      <= free_q - n32_q;
							res_where_q <= a_lo_new[31:0];
						end else begin
							free_q <= free_q + n32_q;
						end
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_p1;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_free_q, out_where_q, out_status_q};

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_RANGES))
		else $error("range count above table size");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok_w))
		else $error("scan token not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n) scan_hit |=> state_q == S_DONE)
		else $error("hit did not finish the request");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !e_valid) |=> res_status_q != aeba_pkg::STAT_OK)
		else $error("exhausted scan reported ok");

endmodule
